### rtl/lapd_pkg.sv
// shared types and constants for the layered box pair detector
// no dependencies; every rtl file imports this package
package lapd_pkg;

   // fixed widths of the request and result fields
   localparam int IDX_W   = 3;
   localparam int LAYER_W = 4;
   localparam int COORD_W = 16;

   // request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_RUN   = 1'b1;

   // scan sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } scan_state_type;

   // per-slot attributes
   typedef struct packed {
      logic               enable;
      logic [LAYER_W-1:0] src_layer;
      logic [LAYER_W-1:0] dst_layer;
      logic               handler;
   } box_attr_type;

   // per-slot geometry
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic        [COORD_W-1:0] w;
      logic        [COORD_W-1:0] h;
   } box_geo_type;

   // slot write request
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      box_attr_type     attr;
      box_geo_type      geo;
   } wr_req_type;

   // one pair of slots, as read request and as evaluation tag
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] src;
      logic [IDX_W-1:0] dst;
   } pair_req_type;

endpackage

### rtl/lapd_box_mem.sv
// box table: geometry and attribute memories with one write and two read ports
// depends on lapd_pkg
module lapd_box_mem #(
   parameter int MAX_BOXES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lapd_pkg::wr_req_type  wr,
   input  lapd_pkg::pair_req_type rd,
   output lapd_pkg::box_attr_type attr_src,
   output lapd_pkg::box_attr_type attr_dst,
   output lapd_pkg::box_geo_type  geo_src,
   output lapd_pkg::box_geo_type  geo_dst
);
   import lapd_pkg::*;

   localparam int AW = $clog2(MAX_BOXES);

   box_geo_type          geo_mem  [MAX_BOXES];
   box_attr_type         attr_mem [MAX_BOXES];
   logic [MAX_BOXES-1:0] valid_ff;
   logic [MAX_BOXES-1:0] valid_in;
   box_attr_type         attr_src_ff, attr_dst_ff;
   box_geo_type          geo_src_ff, geo_dst_ff;
   logic [AW-1:0]        waddr, raddr_s, raddr_d;

   assign waddr   = wr.idx[AW-1:0];
   assign raddr_s = rd.src[AW-1:0];
   assign raddr_d = rd.dst[AW-1:0];

   // memory write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         geo_mem[waddr]  <= wr.geo;
         attr_mem[waddr] <= wr.attr;
      end
   end

   // per-slot written flags, attributes read as zero until written
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // registered read ports for source and destination slot
   always_ff @(posedge clock) begin
      if (rd.en) begin
         geo_src_ff  <= geo_mem[raddr_s];
         geo_dst_ff  <= geo_mem[raddr_d];
         attr_src_ff <= valid_ff[raddr_s] ? attr_mem[raddr_s] : '0;
         attr_dst_ff <= valid_ff[raddr_d] ? attr_mem[raddr_d] : '0;
      end
   end

   assign attr_src = attr_src_ff;
   assign attr_dst = attr_dst_ff;
   assign geo_src  = geo_src_ff;
   assign geo_dst  = geo_dst_ff;

endmodule

### rtl/lapd_overlap_unit.sv
// shared box overlap comparator, one slot pair per use, edges touching count
// depends on lapd_pkg
module lapd_overlap_unit (
   input  lapd_pkg::box_geo_type geo_src,
   input  lapd_pkg::box_geo_type geo_dst,
   output logic                  touch
);
   import lapd_pkg::*;

   // |(2a+sa)-(2b+sb)| <= sa+sb on doubled coordinates
   function automatic logic axis_touch(
      input logic [COORD_W-1:0] pa,
      input logic [COORD_W-1:0] sa,
      input logic [COORD_W-1:0] pb,
      input logic [COORD_W-1:0] sb
   );
      logic [COORD_W+2:0] ca;
      logic [COORD_W+2:0] cb;
      logic [COORD_W+2:0] diff;
      logic [COORD_W+1:0] mag;
      logic [COORD_W:0]   span;
      ca   = {{2{pa[COORD_W-1]}}, pa, 1'b0} + {3'b000, sa};
      cb   = {{2{pb[COORD_W-1]}}, pb, 1'b0} + {3'b000, sb};
      diff = ca - cb;
      if (diff[COORD_W+2]) begin
         mag = (COORD_W+2)'((COORD_W+3)'(0) - diff);
      end else begin
         mag = diff[COORD_W+1:0];
      end
      span = {1'b0, sa} + {1'b0, sb};
      return mag <= {1'b0, span};
   endfunction

   // both axes must touch
   assign touch = axis_touch(geo_src.x, geo_src.w, geo_dst.x, geo_dst.w)
               && axis_touch(geo_src.y, geo_src.h, geo_dst.y, geo_dst.h);

endmodule

### rtl/lapd_scan_ctrl.sv
// pair scan sequencer: walks source and destination slot counters
// depends on lapd_pkg
module lapd_scan_ctrl #(
   parameter int MAX_BOXES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   run_go,
   output logic                   busy,
   output lapd_pkg::pair_req_type rd_req,
   output lapd_pkg::pair_req_type eval,
   output logic                   finish
);
   import lapd_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BOXES - 1);

   scan_state_type   state_ff, state_in;
   logic [IDX_W-1:0] src_ff, src_in, dst_ff, dst_in;
   pair_req_type     eval_ff;
   logic             scan_done;

   assign scan_done = (src_ff == LAST_IDX) && (dst_ff == LAST_IDX);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (run_go) begin
            state_in = ST_SCAN;
         end
         ST_SCAN:   if (scan_done) begin
            state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy   = 1'b1;
      rd_req = '0;
      finish = 1'b0;
      unique case (state_ff)
         ST_IDLE:   busy = 1'b0;
         ST_SCAN:   rd_req = '{en: 1'b1, src: src_ff, dst: dst_ff};
         ST_DRAIN:  ;
         ST_FINISH: finish = 1'b1;
         default:   busy = 1'b0;
      endcase
   end

   // slot counters, destination inner
   always_comb begin
      src_in = src_ff;
      dst_in = dst_ff;
      if (state_ff == ST_SCAN) begin
         if (dst_ff == LAST_IDX) begin
            dst_in = '0;
            src_in = src_ff + 1'b1;
         end else begin
            dst_in = dst_ff + 1'b1;
         end
      end else begin
         src_in = '0;
         dst_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         src_ff   <= '0;
         dst_ff   <= '0;
         eval_ff  <= '0;
      end else begin
         state_ff <= state_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         eval_ff  <= rd_req;
      end
   end

   // evaluation tag lines up with the registered memory read
   assign eval = eval_ff;

   a_eval_follows_scan : assert property (@(posedge clock) disable iff (reset)
      eval_ff.en |-> $past(state_ff) == ST_SCAN)
      else $error("pair evaluated without a scan read");

   a_drain_after_last_pair : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && scan_done |=> state_ff == ST_DRAIN)
      else $error("scan did not end after last pair");

   a_finish_after_drain : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> $past(state_ff) == ST_DRAIN)
      else $error("finish without drain");

endmodule

### rtl/layered_aabb_pair_detector_top.sv
// layered box pair detector: a run over N = MAX_BOXES slots keeps busy high
// while it feeds all N*N ordered slot pairs, one pair per cycle, through the
// overlap comparator; hits are reported during the scan and the final result
// carries last; requests are taken only while busy is low; writes keep it low
// reset clears every slot to disabled; geometry is undefined until written
// depends on lapd_pkg, lapd_box_mem, lapd_overlap_unit, lapd_scan_ctrl
module layered_aabb_pair_detector_top #(
   parameter int MAX_BOXES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_func,
   input  logic [lapd_pkg::IDX_W-1:0]         req_box_index,
   input  logic                               req_entry_enable,
   input  logic [lapd_pkg::LAYER_W-1:0]       req_source_layer,
   input  logic [lapd_pkg::LAYER_W-1:0]       req_dest_layer,
   input  logic signed [lapd_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [lapd_pkg::COORD_W-1:0] req_pos_y,
   input  logic [lapd_pkg::COORD_W-1:0]       req_size_w,
   input  logic [lapd_pkg::COORD_W-1:0]       req_size_h,
   input  logic                               req_has_handler,
   output logic                               rsp_strobe,
   output logic                               rsp_hit_valid,
   output logic [lapd_pkg::IDX_W-1:0]         rsp_source_index,
   output logic [lapd_pkg::IDX_W-1:0]         rsp_dest_index,
   output logic                               rsp_last
);
   import lapd_pkg::*;

   localparam logic [IDX_W:0] SLOT_LIMIT = (IDX_W+1)'(MAX_BOXES);

   wr_req_type       wr;
   pair_req_type     rd_req, eval;
   logic             run_go, finish, touch, hit;
   logic             src_ok, dst_ok;
   box_attr_type     attr_src, attr_dst;
   box_geo_type      geo_src, geo_dst;

   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_src_ff, pend_src_in, pend_dst_ff, pend_dst_in;
   logic             strobe_ff, strobe_in;
   logic             hit_valid_ff, hit_valid_in, last_ff, last_in;
   logic [IDX_W-1:0] out_src_ff, out_src_in, out_dst_ff, out_dst_in;

   // request decode
   assign run_go = start && !busy && (req_func == FUNC_RUN);

   always_comb begin
      wr.en   = start && !busy && (req_func == FUNC_WRITE)
             && ({1'b0, req_box_index} < SLOT_LIMIT);
      wr.idx  = req_box_index;
      wr.attr = '{enable: req_entry_enable, src_layer: req_source_layer,
                  dst_layer: req_dest_layer, handler: req_has_handler};
      wr.geo  = '{x: req_pos_x, y: req_pos_y, w: req_size_w, h: req_size_h};
   end

   lapd_scan_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .run_go (run_go),
      .busy   (busy),
      .rd_req (rd_req),
      .eval   (eval),
      .finish (finish)
   );

   lapd_box_mem #(.MAX_BOXES(MAX_BOXES)) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd       (rd_req),
      .attr_src (attr_src),
      .attr_dst (attr_dst),
      .geo_src  (geo_src),
      .geo_dst  (geo_dst)
   );

   lapd_overlap_unit u_overlap (
      .geo_src (geo_src),
      .geo_dst (geo_dst),
      .touch   (touch)
   );

   // layer filter and handler check on the pair under evaluation
   assign src_ok = attr_src.enable && (attr_src.dst_layer != '0);
   assign dst_ok = attr_dst.enable && (eval.src != eval.dst)
                && (attr_dst.dst_layer == attr_src.src_layer);
   assign hit    = eval.en && src_ok && dst_ok && attr_dst.handler && touch;

   // one hit is held back so the final one can carry last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_src_in   = pend_src_ff;
      pend_dst_in   = pend_dst_ff;
      strobe_in     = 1'b0;
      hit_valid_in  = 1'b0;
      out_src_in    = '0;
      out_dst_in    = '0;
      last_in       = 1'b0;
      if (finish) begin
         strobe_in     = 1'b1;
         hit_valid_in  = pend_valid_ff;
         out_src_in    = pend_valid_ff ? pend_src_ff : '0;
         out_dst_in    = pend_valid_ff ? pend_dst_ff : '0;
         last_in       = 1'b1;
         pend_valid_in = 1'b0;
      end else if (hit) begin
         strobe_in     = pend_valid_ff;
         hit_valid_in  = 1'b1;
         out_src_in    = pend_src_ff;
         out_dst_in    = pend_dst_ff;
         pend_valid_in = 1'b1;
         pend_src_in   = eval.src;
         pend_dst_in   = eval.dst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_src_ff  <= pend_src_in;
      pend_dst_ff  <= pend_dst_in;
      hit_valid_ff <= hit_valid_in;
      out_src_ff   <= out_src_in;
      out_dst_ff   <= out_dst_in;
      last_ff      <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_hit_valid    = hit_valid_ff;
   assign rsp_source_index = out_src_ff;
   assign rsp_dest_index   = out_dst_ff;
   assign rsp_last         = last_ff;

   a_empty_result_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_hit_valid |-> rsp_last)
      else $error("empty result not marked last");

   a_quiet_after_last : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("result right after last of run");

   a_no_write_while_busy : assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr.en)
      else $error("slot written during a run");

   a_pending_clear_when_idle : assert property (@(posedge clock) disable iff (reset)
      !busy |-> !pend_valid_ff)
      else $error("held hit left over after run");

endmodule

### sim/tb.sv
// testbench for layered_aabb_pair_detector_top: slot writes and pair scans,
// checked against an in-bench scan predictor with random sender gaps
// depends on lapd_pkg and the rtl of the detector
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lapd_pkg::*;

   localparam int NUM_SLOTS   = 8;
   // length of one scan, from the request up to its last report
   localparam int SCAN_CYCLES = NUM_SLOTS * NUM_SLOTS + 3;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] src;
      logic [IDX_W-1:0] dst;
      logic             last;
   } pair_report_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_func;
   logic [IDX_W-1:0]          req_box_index;
   logic                      req_entry_enable;
   logic [LAYER_W-1:0]        req_source_layer;
   logic [LAYER_W-1:0]        req_dest_layer;
   logic signed [COORD_W-1:0] req_pos_x;
   logic signed [COORD_W-1:0] req_pos_y;
   logic [COORD_W-1:0]        req_size_w;
   logic [COORD_W-1:0]        req_size_h;
   logic                      req_has_handler;
   logic                      rsp_strobe;
   logic                      rsp_hit_valid;
   logic [IDX_W-1:0]          rsp_source_index;
   logic [IDX_W-1:0]          rsp_dest_index;
   logic                      rsp_last;

   layered_aabb_pair_detector_top #(
      .MAX_BOXES(NUM_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_box_index(req_box_index),
      .req_entry_enable(req_entry_enable),
      .req_source_layer(req_source_layer),
      .req_dest_layer(req_dest_layer),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_size_w(req_size_w),
      .req_size_h(req_size_h),
      .req_has_handler(req_has_handler),
      .rsp_strobe(rsp_strobe),
      .rsp_hit_valid(rsp_hit_valid),
      .rsp_source_index(rsp_source_index),
      .rsp_dest_index(rsp_dest_index),
      .rsp_last(rsp_last)
   );

   // shadow copy of the slot table
   box_attr_type slot_attr [NUM_SLOTS];
   box_geo_type  slot_geo  [NUM_SLOTS];

   pair_report_type pending_reports [$];
   pair_report_type expected_report;

   int error_count     = 0;
   int requests_sent   = 0;
   int scans_sent      = 0;
   int reports_checked = 0;
   int sender_idle_pct = 0;

   always #2 clock = ~clock;

   // doubled-coordinate span test on one axis, touching counts as a hit
   function automatic bit spans_meet(longint pos_a, longint len_a,
                                     longint pos_b, longint len_b);
      longint gap;
      gap = (2 * pos_a + len_a) - (2 * pos_b + len_b);
      if (gap < 0) gap = -gap;
      return gap <= len_a + len_b;
   endfunction

   // all ordered pairs in slot order, reports for handled destinations
   function automatic void predict_scan();
      pair_report_type found [$];
      pair_report_type r;
      bit              x_ok;
      bit              y_ok;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (!slot_attr[s].enable || slot_attr[s].dst_layer == '0) continue;
         for (int d = 0; d < NUM_SLOTS; d++) begin
            if (!slot_attr[d].enable || d == s ||
                slot_attr[d].dst_layer != slot_attr[s].src_layer) continue;
            x_ok = spans_meet(longint'($signed(slot_geo[s].x)), longint'(slot_geo[s].w),
                              longint'($signed(slot_geo[d].x)), longint'(slot_geo[d].w));
            y_ok = spans_meet(longint'($signed(slot_geo[s].y)), longint'(slot_geo[s].h),
                              longint'($signed(slot_geo[d].y)), longint'(slot_geo[d].h));
            if (x_ok && y_ok && slot_attr[d].handler) begin
               r.hit  = 1'b1;
               r.src  = s[IDX_W-1:0];
               r.dst  = d[IDX_W-1:0];
               r.last = 1'b0;
               found  = {found, r};
            end
         end
      end
      // an empty scan still closes with one report
      if (found.size() == 0) begin
         r = '0;
         r.last = 1'b1;
         found  = {found, r};
      end else begin
         found[found.size() - 1].last = 1'b1;
      end
      pending_reports = {pending_reports, found};
   endfunction

   function automatic box_attr_type make_attr(bit en, int src_l, int dst_l, bit hdl);
      box_attr_type a;
      a.enable    = en;
      a.src_layer = src_l[LAYER_W-1:0];
      a.dst_layer = dst_l[LAYER_W-1:0];
      a.handler   = hdl;
      return a;
   endfunction

   function automatic box_geo_type make_geo(int x, int y, int w, int h);
      box_geo_type g;
      g.x = x[COORD_W-1:0];
      g.y = y[COORD_W-1:0];
      g.w = w[COORD_W-1:0];
      g.h = h[COORD_W-1:0];
      return g;
   endfunction

   // random attribute bits
   function automatic box_attr_type rand_attr();
      logic [31:0] bits;
      bits = $urandom;
      return bits[$bits(box_attr_type)-1:0];
   endfunction

   // drive one request, hold it until accepted, then update the prediction
   task automatic send_request(input logic func, input logic [IDX_W-1:0] slot,
                               input box_attr_type attr, input box_geo_type geo);
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_func         <= func;
      req_box_index    <= slot;
      req_entry_enable <= attr.enable;
      req_source_layer <= attr.src_layer;
      req_dest_layer   <= attr.dst_layer;
      req_has_handler  <= attr.handler;
      req_pos_x        <= geo.x;
      req_pos_y        <= geo.y;
      req_size_w       <= geo.w;
      req_size_h       <= geo.h;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
      if (func == FUNC_RUN) begin
         scans_sent++;
         predict_scan();
      end else if (slot < NUM_SLOTS) begin
         slot_attr[slot] = attr;
         slot_geo[slot]  = geo;
      end
   endtask

   task automatic write_box(input int slot, input box_attr_type attr, input box_geo_type geo);
      send_request(FUNC_WRITE, slot[IDX_W-1:0], attr, geo);
   endtask

   // scan request; unused fields carry random bits when noisy
   task automatic run_scan(input bit noisy);
      box_attr_type a;
      box_geo_type  g;
      a = '0;
      g = '0;
      if (noisy) begin
         a = rand_attr();
         g = {$urandom, $urandom};
      end
      send_request(FUNC_RUN, noisy ? IDX_W'($urandom_range(0, 7)) : '0, a, g);
   endtask

   // stop sending until every outstanding report has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   // scan of the table straight after reset: every slot disabled
   task automatic test_empty_table();
      run_scan(1'b0);
   endtask

   // touching edges, one unit apart, and the coordinate extremes
   task automatic test_touch_and_extremes();
      write_box(0, make_attr(1, 1, 2, 1), make_geo(0, 0, 10, 10));
      write_box(1, make_attr(1, 2, 1, 1), make_geo(10, 5, 6, 6));
      run_scan(1'b0);
      write_box(1, make_attr(1, 2, 1, 1), make_geo(11, 5, 6, 6));
      run_scan(1'b0);
      write_box(0, make_attr(1, 1, 2, 1), make_geo(-32768, -32768, 65535, 65535));
      write_box(1, make_attr(1, 2, 1, 1), make_geo(32767, 32767, 0, 0));
      run_scan(1'b0);
   endtask

   // no dest layer, layer mismatch, missing handler, disabled slot, self pair
   task automatic test_layer_filters();
      write_box(0, make_attr(1, 3, 0, 1), make_geo(0, 0, 4, 4));
      write_box(1, make_attr(1, 5, 3, 1), make_geo(0, 0, 4, 4));
      write_box(2, make_attr(1, 3, 3, 0), make_geo(1, 1, 4, 4));
      write_box(3, make_attr(0, 3, 3, 1), make_geo(2, 2, 4, 4));
      write_box(4, make_attr(1, 15, 15, 1), make_geo(0, 0, 4, 4));
      run_scan(1'b0);
      wait_for_drain();
      write_box(1, make_attr(0, 5, 3, 1), make_geo(0, 0, 4, 4));
      run_scan(1'b0);
   endtask

   // every slot sees every other one: the most hits a scan can report
   task automatic test_full_table();
      for (int i = 0; i < NUM_SLOTS; i++)
         write_box(i, make_attr(1, 1, 1, 1), make_geo(-5, -5, 10, 10));
      run_scan(1'b0);
   endtask

   // mostly short write bursts followed by a scan, some noise between
   task automatic test_random_traffic(input int idle_pct, input int count);
      int target;
      int n_writes;
      box_attr_type a;
      box_geo_type  g;
      sender_idle_pct = idle_pct;
      target = requests_sent + count;
      while (requests_sent < target) begin
         n_writes = 0;
         case ($urandom_range(0, 9))
            0: n_writes = 0;
            1: begin
               a = rand_attr();
               g = {$urandom, $urandom};
               write_box($urandom_range(0, 7), a, g);
               continue;
            end
            default: n_writes = $urandom_range(1, 4);
         endcase
         repeat (n_writes) begin
            if ($urandom_range(0, 4) == 0) begin
               a = rand_attr();
               g = {$urandom, $urandom};
            end else begin
               a = make_attr($urandom_range(0, 9) != 0, $urandom_range(0, 3),
                             $urandom_range(0, 3), $urandom_range(0, 3) != 0);
               g = make_geo(int'($urandom_range(0, 80)) - 40,
                            int'($urandom_range(0, 80)) - 40,
                            $urandom_range(0, 40), $urandom_range(0, 40));
            end
            write_box($urandom_range(0, 7), a, g);
         end
         run_scan($urandom_range(0, 1));
      end
      wait_for_drain();
   endtask

   // compare each strobed report with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            error_count++;
            $display("%0t: unexpected report hit=%0b src=%0d dst=%0d last=%0b", $time,
                     rsp_hit_valid, rsp_source_index, rsp_dest_index, rsp_last);
         end else begin
            expected_report = pending_reports.pop_front();
            reports_checked++;
            if (rsp_hit_valid !== expected_report.hit ||
                rsp_source_index !== expected_report.src ||
                rsp_dest_index !== expected_report.dst ||
                rsp_last !== expected_report.last) begin
               error_count++;
               $display("%0t: report mismatch expected hit=%0b src=%0d dst=%0d last=%0b",
                        $time, expected_report.hit, expected_report.src,
                        expected_report.dst, expected_report.last);
               $display("%0t:                 actual   hit=%0b src=%0d dst=%0d last=%0b",
                        $time, rsp_hit_valid, rsp_source_index, rsp_dest_index, rsp_last);
            end
         end
      end
   end

   // run watchdog
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_func         <= FUNC_WRITE;
      req_box_index    <= '0;
      req_entry_enable <= 1'b0;
      req_source_layer <= '0;
      req_dest_layer   <= '0;
      req_pos_x        <= '0;
      req_pos_y        <= '0;
      req_size_w       <= '0;
      req_size_h       <= '0;
      req_has_handler  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_attr[i] = '0;
         slot_geo[i]  = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_touch_and_extremes();
      test_layer_filters();
      test_full_table();
      wait_for_drain();
      test_random_traffic(20, 32);
      test_random_traffic(58, 32);
      test_random_traffic(0, 32);

      // let any late report show up before closing
      wait_for_drain();
      repeat (SCAN_CYCLES + 8) @(posedge clock);

      $display("covered %0d requests including %0d scans, %0d reports checked",
               requests_sent, scans_sent, reports_checked);
      $display("directed edge, layer and full-table cases plus three sender gap mixes");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
